FILE: design/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg: shared types and constants for the per-address rate limiter
// Configuration defaults, register indexes, the request record that walks
// the cell chain, and the timer liveness helper.
// ----------------------------------------------------------------------------
package prl_pkg;

  // Table size default
  localparam int unsigned TABLE_ENTRIES_DEFAULT = 64;

  // Field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SPAN_W  = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SECONDS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCESSES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 2'd2;

  // Register values after reset
  localparam logic [SPAN_W-1:0]  BLOCK_SECONDS_RESET  = 16'd60;
  localparam logic [COUNT_W-1:0] MAX_ACCESSES_RESET   = 16'd100;
  localparam logic [SPAN_W-1:0]  WINDOW_SECONDS_RESET = 16'd10;

  // Counter limits
  localparam logic [COUNT_W-1:0] COUNT_ONE = 16'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Configuration seen by every cell
  typedef struct packed {
    logic [SPAN_W-1:0]  block_seconds;
    logic [COUNT_W-1:0] max_accesses;
    logic [SPAN_W-1:0]  window_seconds;
  } cfg_t;

  // Request record handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
    logic              matched;      // some cell owned this address
    logic              allowed;      // verdict from the owning cell
    logic              claim_found;  // a free cell was seen on the way
  } pkt_t;

  // Claim write broadcast at the end of the chain
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
  } claim_t;

  // Timer is live while flagged and the modular age is below the span
  function automatic logic timer_live(input logic              flag,
                                      input logic [TIME_W-1:0] start,
                                      input logic [TIME_W-1:0] now,
                                      input logic [SPAN_W-1:0] span);
    logic [TIME_W-1:0] age;
    age = now - start;
    return flag && (age < {{(TIME_W-SPAN_W){1'b0}}, span});
  endfunction

endpackage

FILE: design/prl_cell.sv
// ----------------------------------------------------------------------------
// prl_cell: one table entry of the rate limiter
// Holds one address with its window and block timers. A passing request is
// checked against the entry, updated in place if the entry owns the address,
// and handed on to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module prl_cell #(
  parameter int unsigned IDX_W = 6,
  parameter int unsigned INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  prl_pkg::cfg_t       cfg,
  input  prl_pkg::pkt_t       pkt_in,
  input  logic [IDX_W-1:0]    idx_in,
  output prl_pkg::pkt_t       pkt_out,
  output logic [IDX_W-1:0]    idx_out,
  input  prl_pkg::claim_t     claim,
  input  logic [IDX_W-1:0]    claim_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  // Entry state
  logic [prl_pkg::ADDR_W-1:0]  entry_address, entry_address_next;
  logic                        window_live, window_live_next;
  logic [prl_pkg::COUNT_W-1:0] access_count, access_count_next;
  logic [prl_pkg::TIME_W-1:0]  window_start, window_start_next;
  logic                        block_live, block_live_next;
  logic [prl_pkg::TIME_W-1:0]  block_start, block_start_next;

  prl_pkg::pkt_t    pkt_next;
  logic [IDX_W-1:0] idx_next;

  logic flag_match, win_on, blk_on, is_free;

  // Match and timer checks against the passing request
  always_comb begin
    flag_match = (window_live || block_live) && (entry_address == pkt_in.addr);
    win_on = prl_pkg::timer_live(window_live, window_start, pkt_in.now,
                                 cfg.window_seconds);
    blk_on = prl_pkg::timer_live(block_live, block_start, pkt_in.now,
                                 cfg.block_seconds);
    is_free = !win_on && !blk_on;
  end

  // Request handling and claim write
  always_comb begin
    pkt_next           = pkt_in;
    idx_next           = idx_in;
    entry_address_next = entry_address;
    window_live_next   = window_live;
    access_count_next  = access_count;
    window_start_next  = window_start;
    block_live_next    = block_live;
    block_start_next   = block_start;

    if (pkt_in.valid && !pkt_in.matched) begin
      if (flag_match) begin
        pkt_next.matched = 1'b1;
        if (blk_on) begin
          pkt_next.allowed = 1'b0;
        end else if (!win_on) begin
          // fresh window
          block_live_next   = 1'b0;
          window_live_next  = 1'b1;
          window_start_next = pkt_in.now;
          access_count_next = prl_pkg::COUNT_ONE;
          pkt_next.allowed  = 1'b1;
        end else if (access_count >= cfg.max_accesses) begin
          // window exhausted: start a block
          block_live_next  = 1'b1;
          block_start_next = pkt_in.now;
          pkt_next.allowed = 1'b0;
        end else begin
          if (access_count != prl_pkg::COUNT_MAX) begin
            access_count_next = access_count + prl_pkg::COUNT_ONE;
          end
          pkt_next.allowed = 1'b1;
        end
      end else if (!pkt_in.claim_found && is_free) begin
        pkt_next.claim_found = 1'b1;
        idx_next             = MY_IDX;
      end
    end

    // Claim of this entry for a new address, starts a window at once
    if (claim.valid && (claim_idx == MY_IDX)) begin
      entry_address_next = claim.addr;
      window_live_next   = 1'b1;
      window_start_next  = claim.now;
      access_count_next  = prl_pkg::COUNT_ONE;
      block_live_next    = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_live   <= 1'b0;
      block_live    <= 1'b0;
      pkt_out.valid <= 1'b0;
    end else begin
      window_live   <= window_live_next;
      block_live    <= block_live_next;
      pkt_out.valid <= pkt_next.valid;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    entry_address       <= entry_address_next;
    access_count        <= access_count_next;
    window_start        <= window_start_next;
    block_start         <= block_start_next;
    pkt_out.addr        <= pkt_next.addr;
    pkt_out.now         <= pkt_next.now;
    pkt_out.matched     <= pkt_next.matched;
    pkt_out.allowed     <= pkt_next.allowed;
    pkt_out.claim_found <= pkt_next.claim_found;
    idx_out             <= idx_next;
  end

endmodule

FILE: design/per_address_access_rate_limiter_core.sv
// One access at a time: in_ready is low from input transfer until the result
//   moves to the output register. The request walks the cell chain one entry
//   per cycle, then a free entry is claimed if needed.
// A finished result waits in the output register while the next access runs.
// Reset (rst, synchronous): all entries go idle, registers take their defaults;
//   there is no clearing pass, the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
// per_address_access_rate_limiter_core: fixed window limiter with blocklist
// Chain of table cells with request injection, claim write-back, result
// staging and the configuration registers.
// ----------------------------------------------------------------------------
module per_address_access_rate_limiter_core #(
  parameter int unsigned TABLE_ENTRIES = prl_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [prl_pkg::ADDR_W-1:0]     client_address,
  input  logic [prl_pkg::TIME_W-1:0]     now_seconds,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           allowed,
  output logic                           untracked,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [prl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  prl_pkg::cfg_t   cfg;
  prl_pkg::pkt_t   pkt [0:TABLE_ENTRIES];
  logic [IDX_W-1:0] idx [0:TABLE_ENTRIES];
  prl_pkg::claim_t claim;
  logic [TABLE_ENTRIES-1:0] live_vec;

  logic busy;
  logic pend_valid, pend_allowed, pend_untracked;
  logic pend_move, in_xfer, last_valid;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign in_xfer   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_seconds  <= prl_pkg::BLOCK_SECONDS_RESET;
      cfg.max_accesses   <= prl_pkg::MAX_ACCESSES_RESET;
      cfg.window_seconds <= prl_pkg::WINDOW_SECONDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        prl_pkg::REG_BLOCK_SECONDS:  cfg.block_seconds  <= cfg_data;
        prl_pkg::REG_MAX_ACCESSES:   cfg.max_accesses   <= cfg_data;
        prl_pkg::REG_WINDOW_SECONDS: cfg.window_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request injection at the head of the chain
  always_comb begin
    pkt[0].valid       = in_xfer;
    pkt[0].addr        = client_address;
    pkt[0].now         = now_seconds;
    pkt[0].matched     = 1'b0;
    pkt[0].allowed     = 1'b0;
    pkt[0].claim_found = 1'b0;
    idx[0]             = '0;
  end

  // Cell chain
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    prl_cell #(
      .IDX_W (IDX_W),
      .INDEX (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .pkt_in    (pkt[g]),
      .idx_in    (idx[g]),
      .pkt_out   (pkt[g+1]),
      .idx_out   (idx[g+1]),
      .claim     (claim),
      .claim_idx (idx[TABLE_ENTRIES])
    );
    assign live_vec[g] = pkt[g+1].valid;
  end

  // Tail of the chain: claim a free entry when no owner was found
  assign last_valid  = pkt[TABLE_ENTRIES].valid;
  assign claim.valid = last_valid && !pkt[TABLE_ENTRIES].matched
                       && pkt[TABLE_ENTRIES].claim_found;
  assign claim.addr  = pkt[TABLE_ENTRIES].addr;
  assign claim.now   = pkt[TABLE_ENTRIES].now;

  assign pend_move = pend_valid && (!out_valid || out_ready);

  // Busy from input transfer until the result reaches the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy <= 1'b1;
      end else if (pend_move) begin
        busy <= 1'b0;
      end
      if (last_valid) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (last_valid) begin
      pend_allowed   <= pkt[TABLE_ENTRIES].matched ? pkt[TABLE_ENTRIES].allowed : 1'b1;
      pend_untracked <= !pkt[TABLE_ENTRIES].matched && !pkt[TABLE_ENTRIES].claim_found;
    end
    if (pend_move) begin
      allowed   <= pend_allowed;
      untracked <= pend_untracked;
    end
  end

  // At most one request in the chain at any time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0(live_vec))
    else $error("more than one request in the cell chain");

  // A request in the chain or a staged result means the block is busy
  a_busy_cover: assert property (@(posedge clk) disable iff (rst)
    ((|live_vec) || pend_valid) |-> busy)
    else $error("request in flight while not busy");

  // A claim write never follows a request that found its owner
  a_claim_unmatched: assert property (@(posedge clk) disable iff (rst)
    claim.valid |-> !pkt[TABLE_ENTRIES].matched)
    else $error("claim issued for an owned address");

  // An untracked access is always allowed
  a_untracked_allowed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && untracked) |-> allowed)
    else $error("untracked access refused");

  // A staged result is not overwritten by a new one
  a_pend_free: assert property (@(posedge clk) disable iff (rst)
    last_valid |-> !pend_valid)
    else $error("result staging overrun");

endmodule
